[rtl/nfac_pkg.sv]
// shared types and constants of the normal force admittance controller
package nfac_pkg;

    localparam int Q_FRAC = 16;
    localparam logic [63:0] NORMAL_MIN_SQ = 64'd4;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ENABLE         = 3'd0;
    localparam logic [2:0] REG_APPROACH       = 3'd1;
    localparam logic [2:0] REG_TARGET_FORCE   = 3'd2;
    localparam logic [2:0] REG_MAX_VELOCITY   = 3'd3;
    localparam logic [2:0] REG_RESPONSE_GAIN  = 3'd4;
    localparam logic [2:0] REG_VELOCITY_GAIN  = 3'd5;
    localparam logic [2:0] REG_FORCE_DEADBAND = 3'd6;
    localparam logic [2:0] REG_APPROACH_SPEED = 3'd7;

    localparam logic [30:0] RESPONSE_GAIN_RESET = 31'd65536;

    // pipeline stage map
    localparam int ST_IN       = 0;
    localparam int ST_SQ       = 1;
    localparam int ST_SUM      = 2;
    localparam int ST_NORM     = 3;
    localparam int ST_SQ2      = 4;
    localparam int ST_X        = 5;
    localparam int GD_FIRST    = 5;
    localparam int GD_STEPS    = 31;
    localparam int SQ_FIRST    = 6;
    localparam int SQ_STEPS    = 32;
    localparam int ST_REL      = GD_FIRST + GD_STEPS;
    localparam int ST_UINIT    = SQ_FIRST + SQ_STEPS;
    localparam int UD_FIRST    = ST_UINIT + 1;
    localparam int UD_STEPS    = 17;
    localparam int ST_U        = UD_FIRST + UD_STEPS;
    localparam int ST_SSUM     = ST_U + 1;
    localparam int ST_SURF     = ST_U + 2;
    localparam int ST_ROBOT    = ST_U + 3;
    localparam int ST_CMDP     = ST_U + 4;
    localparam int ST_CMD      = ST_U + 5;
    localparam int NSTAGE      = ST_CMD + 1;

    typedef struct packed {
        logic        enable;
        logic        approach;
        logic [30:0] target_force;
        logic [30:0] max_velocity;
        logic [30:0] response_gain;
        logic [31:0] velocity_gain;
        logic [30:0] force_deadband;
        logic [30:0] approach_speed;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [2:0][31:0] v;
        logic [2:0][31:0] a;
        logic [31:0]      err;
        logic [31:0]      db;
        logic             contact;
        logic             act;
        logic             appr;
        logic             valid;
        logic [2:0][62:0] sqp;
        logic [31:0]      m;
        logic [63:0]      prod;
        logic             prod_neg;
        logic [62:0]      gn;
        logic             ovf;
        logic [31:0]      grem;
        logic [30:0]      gq;
        logic [63:0]      x;
        logic [31:0]      root;
        logic [33:0]      srem;
        logic [31:0]      rel;
        logic [2:0][16:0] unum;
        logic [2:0][31:0] urem;
        logic [2:0][16:0] uq;
        logic [2:0][17:0] u;
        logic [2:0][49:0] pr;
        logic [51:0]      ssum;
        logic [31:0]      surf;
        logic [31:0]      robot;
        logic [2:0][31:0] cmd;
    } pipe_t;

    typedef struct packed {
        logic [2:0][31:0] cmd;
        logic [31:0]      robot;
        logic [31:0]      rel;
        logic [31:0]      surf;
        logic [31:0]      err;
        logic             normal_ok;
        logic             active;
        logic             approaching;
        logic             releasing;
    } result_t;

endpackage

[rtl/normal_force_admittance_controller.sv]
// normal force admittance controller: top level with the full sample pipeline
// One sample enters per clock while the pipeline is not held, and its command
// leaves through 62 pipeline stages and the output register. The depth is set by
// the 32-stage bit-per-stage square root of the normal's squared length,
// followed by the 17-stage divider that scales the normal to unit length; the
// gain divider (31 stages) runs beside the square root. All values are Q16.16.
// The whole pipeline, bubbles included, holds while the output register keeps
// an untaken result and the last stage is full. The user must write registers
// only while no sample is in flight; the block itself does not enforce this.
module normal_force_admittance_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    input  logic [31:0] surface_vel_x,
    input  logic [31:0] surface_vel_y,
    input  logic [31:0] surface_vel_z,
    input  logic [31:0] measured_force,
    input  logic        in_contact,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] cmd_vel_x,
    output logic [31:0] cmd_vel_y,
    output logic [31:0] cmd_vel_z,
    output logic [31:0] robot_normal_velocity,
    output logic [31:0] relative_normal_velocity,
    output logic [31:0] surface_normal_velocity,
    output logic [31:0] force_error,
    output logic        normal_ok,
    output logic        active,
    output logic        approaching,
    output logic        releasing
);
    import nfac_pkg::*;

    cfg_t    cfg_reg;
    pipe_t   pipe_reg  [NSTAGE];
    pipe_t   pipe_next [NSTAGE];
    logic    vld_reg   [NSTAGE];
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_load;
    logic    adv;

    // signed value divided by 2^16, rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] rnd_sat(input logic [51:0] x);
        logic [51:0] mag;
        logic [36:0] q;
        mag = x[51] ? (52'd0 - x) : x;
        q   = 37'((mag + 52'd32768) >> Q_FRAC);
        if (x[51])
            rnd_sat = (q > 37'h080000000) ? 32'h80000000 : 32'(37'd0 - q);
        else
            rnd_sat = (q > 37'h07fffffff) ? 32'h7fffffff : q[31:0];
    endfunction

    function automatic pipe_t stage_fn(input pipe_t p, input int k, input cfg_t c);
        pipe_t              q;
        logic [4:0]         s;
        logic [63:0]        pm;
        logic [30:0]        rge;
        logic [32:0]        t33;
        logic [35:0]        t36;
        logic [35:0]        tr36;
        logic [47:0]        un;
        logic [31:0]        e;
        logic [31:0]        dbm;
        logic [31:0]        mag;
        logic signed [32:0] rs;
        logic signed [51:0] wide;
        q   = p;
        rge = (c.response_gain == 31'd0) ? 31'd1 : c.response_gain;
        if (k == ST_SQ) begin
            for (int i = 0; i < 3; i++)
                q.sqp[i] = 63'({32'd0, p.a[i]} * {32'd0, p.a[i]});
            e = p.err[31] ? (32'd0 - p.err) : p.err;
            q.db = 32'd0;
            if (e > {1'b0, c.force_deadband}) begin
                dbm  = e - {1'b0, c.force_deadband};
                q.db = p.err[31] ? (32'd0 - dbm) : dbm;
            end
        end
        if (k == ST_SUM) begin
            q.x     = 64'(p.sqp[0]) + 64'(p.sqp[1]) + 64'(p.sqp[2]);
            q.valid = q.x > NORMAL_MIN_SQ;
            q.m     = p.a[0];
            if (p.a[1] > q.m)
                q.m = p.a[1];
            if (p.a[2] > q.m)
                q.m = p.a[2];
            q.prod  = $signed(c.velocity_gain) * $signed(p.db);
        end
        if (k == ST_NORM) begin
            // shift that brings the largest component up to bit 30
            s = 5'd0;
            for (int i = 0; i < 31; i++)
                if (p.m[i])
                    s = 5'(30 - i);
            for (int i = 0; i < 3; i++)
                q.a[i] = p.a[i] << s;
            pm         = p.prod[63] ? (64'd0 - p.prod) : p.prod;
            q.gn       = 63'(pm) + 63'(rge >> 1);
            q.prod_neg = p.prod[63];
        end
        if (k == ST_SQ2) begin
            for (int i = 0; i < 3; i++)
                q.sqp[i] = 63'({32'd0, p.a[i]} * {32'd0, p.a[i]});
            q.ovf  = {1'b0, p.gn} >= (64'(rge) << 31);
            q.grem = p.gn[62:31];
            q.gq   = 31'd0;
        end
        if (k == ST_X) begin
            q.x    = 64'(p.sqp[0]) + 64'(p.sqp[1]) + 64'(p.sqp[2]);
            q.root = 32'd0;
            q.srem = 34'd0;
        end
        if (k >= GD_FIRST && k < GD_FIRST + GD_STEPS) begin
            t33 = {q.grem, q.gn[GD_FIRST + 30 - k]};
            if (t33 >= 33'(rge)) begin
                q.grem = 32'(t33 - 33'(rge));
                q.gq   = {q.gq[29:0], 1'b1};
            end else begin
                q.grem = t33[31:0];
                q.gq   = {q.gq[29:0], 1'b0};
            end
        end
        if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) begin
            t36  = {q.srem, q.x[63:62]};
            tr36 = {2'b00, q.root, 2'b01};
            if (t36 >= tr36) begin
                q.srem = 34'(t36 - tr36);
                q.root = {q.root[30:0], 1'b1};
            end else begin
                q.srem = t36[33:0];
                q.root = {q.root[30:0], 1'b0};
            end
            q.x = {q.x[61:0], 2'b00};
        end
        if (k == ST_REL) begin
            if (p.ovf || (p.gq > c.max_velocity))
                mag = {1'b0, c.max_velocity};
            else
                mag = {1'b0, p.gq};
            if (p.appr)
                q.rel = (c.approach_speed > c.max_velocity) ? {1'b0, c.max_velocity}
                                                            : {1'b0, c.approach_speed};
            else if (p.act)
                q.rel = p.prod_neg ? (32'd0 - mag) : mag;
            else
                q.rel = 32'd0;
        end
        if (k == ST_UINIT) begin
            for (int i = 0; i < 3; i++) begin
                un        = {p.a[i], 16'd0} + 48'(p.root >> 1);
                q.urem[i] = 32'(un[47:17]);
                q.unum[i] = un[16:0];
                q.uq[i]   = 17'd0;
            end
        end
        if (k >= UD_FIRST && k < UD_FIRST + UD_STEPS) begin
            for (int i = 0; i < 3; i++) begin
                t33 = {p.urem[i], p.unum[i][16]};
                if (t33 >= 33'(p.root)) begin
                    q.urem[i] = 32'(t33 - 33'(p.root));
                    q.uq[i]   = {p.uq[i][15:0], 1'b1};
                end else begin
                    q.urem[i] = t33[31:0];
                    q.uq[i]   = {p.uq[i][15:0], 1'b0};
                end
                q.unum[i] = {p.unum[i][15:0], 1'b0};
            end
        end
        if (k == ST_U) begin
            for (int i = 0; i < 3; i++) begin
                q.u[i]  = p.n[i][31] ? (18'd0 - {1'b0, p.uq[i]}) : {1'b0, p.uq[i]};
                q.pr[i] = $signed(q.u[i]) * $signed(p.v[i]);
            end
        end
        if (k == ST_SSUM) begin
            wide   = $signed(p.pr[0]) + $signed(p.pr[1]) + $signed(p.pr[2]);
            q.ssum = wide;
        end
        if (k == ST_SURF)
            q.surf = rnd_sat(p.ssum);
        if (k == ST_ROBOT) begin
            rs = $signed(p.surf) + $signed(p.rel);
            if (rs > 33'sh07fffffff)
                q.robot = 32'h7fffffff;
            else if (rs < -33'sh080000000)
                q.robot = 32'h80000000;
            else
                q.robot = rs[31:0];
        end
        if (k == ST_CMDP) begin
            for (int i = 0; i < 3; i++)
                q.pr[i] = $signed(p.u[i]) * $signed(p.robot);
        end
        if (k == ST_CMD) begin
            for (int i = 0; i < 3; i++) begin
                wide     = $signed(p.pr[i]);
                q.cmd[i] = rnd_sat(wide);
            end
        end
        return q;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= '0;
            cfg_reg.response_gain <= RESPONSE_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:         cfg_reg.enable         <= cfg_data[0];
                REG_APPROACH:       cfg_reg.approach       <= cfg_data[0];
                REG_TARGET_FORCE:   cfg_reg.target_force   <= cfg_data[30:0];
                REG_MAX_VELOCITY:   cfg_reg.max_velocity   <= cfg_data[30:0];
                REG_RESPONSE_GAIN:  cfg_reg.response_gain  <= cfg_data[30:0];
                REG_VELOCITY_GAIN:  cfg_reg.velocity_gain  <= cfg_data;
                REG_FORCE_DEADBAND: cfg_reg.force_deadband <= cfg_data[30:0];
                REG_APPROACH_SPEED: cfg_reg.approach_speed <= cfg_data[30:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // entry stage and the rest of the pipeline
    always_comb
    begin
        pipe_next[ST_IN]         = '0;
        pipe_next[ST_IN].n[0]    = normal_x;
        pipe_next[ST_IN].n[1]    = normal_y;
        pipe_next[ST_IN].n[2]    = normal_z;
        pipe_next[ST_IN].v[0]    = surface_vel_x;
        pipe_next[ST_IN].v[1]    = surface_vel_y;
        pipe_next[ST_IN].v[2]    = surface_vel_z;
        for (int i = 0; i < 3; i++)
            pipe_next[ST_IN].a[i] = pipe_next[ST_IN].n[i][31] ?
                                    (32'd0 - pipe_next[ST_IN].n[i]) : pipe_next[ST_IN].n[i];
        // measured force clipped at zero
        pipe_next[ST_IN].err     = {1'b0, cfg_reg.target_force} -
                                   (measured_force[31] ? 32'd0 : measured_force);
        pipe_next[ST_IN].contact = in_contact;
        pipe_next[ST_IN].act     = in_contact | cfg_reg.approach;
        pipe_next[ST_IN].appr    = !in_contact && cfg_reg.approach &&
                                   (cfg_reg.target_force != 31'd0);
        for (int k = 1; k < NSTAGE; k++)
            pipe_next[k] = stage_fn(pipe_reg[k-1], k, cfg_reg);
    end

    assign out_load = vld_reg[NSTAGE-1] && (!out_valid_reg || out_ready);
    assign adv      = !vld_reg[NSTAGE-1] || out_load;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTAGE; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTAGE; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NSTAGE; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    // result assembly; disabled or bad normal gives zero commands
    always_comb
    begin
        out_next           = '0;
        out_next.normal_ok = pipe_reg[NSTAGE-1].valid;
        if (cfg_reg.enable && pipe_reg[NSTAGE-1].valid)
        begin
            out_next.cmd         = pipe_reg[NSTAGE-1].cmd;
            out_next.robot       = pipe_reg[NSTAGE-1].robot;
            out_next.rel         = pipe_reg[NSTAGE-1].rel;
            out_next.surf        = pipe_reg[NSTAGE-1].surf;
            out_next.err         = pipe_reg[NSTAGE-1].err;
            out_next.active      = pipe_reg[NSTAGE-1].act;
            out_next.approaching = pipe_reg[NSTAGE-1].appr;
            out_next.releasing   = pipe_reg[NSTAGE-1].act && pipe_reg[NSTAGE-1].rel[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign out_valid                = out_valid_reg;
    assign cmd_vel_x                = out_reg.cmd[0];
    assign cmd_vel_y                = out_reg.cmd[1];
    assign cmd_vel_z                = out_reg.cmd[2];
    assign robot_normal_velocity    = out_reg.robot;
    assign relative_normal_velocity = out_reg.rel;
    assign surface_normal_velocity  = out_reg.surf;
    assign force_error              = out_reg.err;
    assign normal_ok                = out_reg.normal_ok;
    assign active                   = out_reg.active;
    assign approaching              = out_reg.approaching;
    assign releasing                = out_reg.releasing;

`ifndef SYNTH
    // unit components never exceed one
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_U-1] && pipe_reg[ST_U-1].valid |->
            pipe_reg[ST_U-1].uq[0] <= 17'h10000 && pipe_reg[ST_U-1].uq[1] <= 17'h10000 &&
            pipe_reg[ST_U-1].uq[2] <= 17'h10000)
        else $error("unit normal component above one");

    a_bad_normal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !normal_ok |->
            cmd_vel_x == 32'd0 && cmd_vel_y == 32'd0 && cmd_vel_z == 32'd0 && !active)
        else $error("command issued for an invalid normal");

    a_approach_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && approaching |-> active && !releasing)
        else $error("approach flag without active");

    a_rel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            $signed(relative_normal_velocity) <= $signed({1'b0, cfg_reg.max_velocity}) &&
            $signed(relative_normal_velocity) >= -$signed({1'b0, cfg_reg.max_velocity}))
        else $error("relative velocity outside clamp");

    a_release_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && releasing |-> relative_normal_velocity[31] && active)
        else $error("releasing flag with non-negative velocity");
`endif

endmodule
